### rtl/core/bsa_pkg.sv
// ----------------------------------------------------------------------------
// bsa_pkg
// Shared types and field widths of the binding slot allocator.
// ----------------------------------------------------------------------------
`default_nettype none

package bsa_pkg;

  // Field widths of the stream payloads
  localparam int unsigned FUNC_W  = 2;
  localparam int unsigned SPACE_W = 4;
  localparam int unsigned SLOT_W  = 7;
  localparam int unsigned GRANT_W = 6;
  localparam int unsigned START_W = 6;
  localparam int unsigned IN_DATA_W  = 16;
  localparam int unsigned OUT_DATA_W = 8;
  localparam int unsigned CFG_IDX_W  = 1;

  // Request kinds
  typedef enum logic [FUNC_W-1:0] {
    FUNC_RESERVE       = 2'd0,
    FUNC_TAKE_AUTO     = 2'd1,
    FUNC_TAKE_BINDLESS = 2'd2,
    FUNC_RESTART       = 2'd3
  } func_t;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_AUTO_START     = 1'b0,
    CFG_BINDLESS_START = 1'b1
  } cfg_idx_t;

  // Sequencer states, one-hot
  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_EXEC = 2'b10
  } state_t;

endpackage

`default_nettype wire

### rtl/core/binding_slot_allocator_top.sv
// ----------------------------------------------------------------------------
// binding_slot_allocator_top
// Next-fit bitmap slot allocator with per-space auto and bindless cursors.
// ----------------------------------------------------------------------------
// Each request runs as an issue step and an execute step: the issue step
// starts the synchronous read of the space's bitmap word and cursor pair, the
// execute step searches the word with a masked priority encoder, writes both
// memories back and loads the result register. The read-modify-write of one
// memory entry keeps one request in flight at a time; a new request is
// taken only when the output register is empty or its result leaves at the
// same edge, so a stalled result holds off the next request. No clearing pass
// runs after reset: per-space valid flags make unwritten bitmap words read
// as empty and unstarted cursors read as the configured start slot.
// ----------------------------------------------------------------------------
`default_nettype none

module binding_slot_allocator_top
  import bsa_pkg::*;
#(
  parameter int unsigned SLOTS  = 64,
  parameter int unsigned SPACES = 8
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  // Request channel
  input  wire logic                  in_tvalid,
  output logic                       in_tready,
  input  wire logic [IN_DATA_W-1:0]  in_tdata,   // space[3:0], slot[10:4], zero pad
  input  wire logic [FUNC_W-1:0]     in_tuser,   // func[1:0]
  // Result channel
  output logic                       out_tvalid,
  input  wire logic                  out_tready,
  output logic      [OUT_DATA_W-1:0] out_tdata,  // granted_slot[5:0], zero pad
  output logic                       out_tuser,  // full_res[0]
  // Configuration
  input  wire logic                  cfg_wr_en,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [START_W-1:0]    cfg_wdata
);

  localparam int unsigned SW = (SPACES > 1) ? $clog2(SPACES) : 1;
  localparam int unsigned LW = $clog2(SLOTS);
  localparam int unsigned CW = ($clog2(SLOTS + 1) > START_W) ? $clog2(SLOTS + 1) : START_W;

  // Configuration registers
  logic [START_W-1:0] auto_start_r;
  logic [START_W-1:0] bl_start_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      auto_start_r <= '0;
      bl_start_r   <= '0;
    end else if (cfg_wr_en) begin
      case (cfg_idx_t'(cfg_index))
        CFG_AUTO_START:     auto_start_r <= cfg_wdata;
        CFG_BINDLESS_START: bl_start_r   <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Request decode
  logic              in_accept;
  logic [SPACE_W-1:0] in_space;
  logic [SLOT_W-1:0]  in_slot;
  logic [31:0]        in_space_ext;
  logic [31:0]        in_slot_ext;
  logic               in_sp_ok;
  logic               in_slot_ok;
  logic [SW-1:0]      in_sp_idx;
  logic [LW-1:0]      in_slot_idx;

  state_t state_r, state_nxt;
  logic   out_valid_r;

  assign in_tready    = (state_r == ST_IDLE) && (!out_valid_r || out_tready);
  assign in_accept    = in_tvalid && in_tready;
  assign in_space     = in_tdata[3:0];
  assign in_slot      = in_tdata[10:4];
  assign in_space_ext = 32'(in_space[SPACE_W-2:0]);
  assign in_slot_ext  = 32'(in_slot[SLOT_W-2:0]);
  assign in_sp_ok     = !in_space[SPACE_W-1] && (in_space_ext < SPACES);
  assign in_slot_ok   = !in_slot[SLOT_W-1] && (in_slot_ext < SLOTS);
  assign in_sp_idx    = in_space_ext[SW-1:0];
  assign in_slot_idx  = in_slot_ext[LW-1:0];

  // Hold the accepted request
  func_t         req_func_r;
  logic [SW-1:0] req_sp_r;
  logic          req_sp_ok_r;
  logic [LW-1:0] req_slot_r;
  logic          req_slot_ok_r;

  always_ff @(posedge clk) begin
    if (in_accept) begin
      req_func_r    <= func_t'(in_tuser);
      req_sp_r      <= in_sp_idx;
      req_sp_ok_r   <= in_sp_ok;
      req_slot_r    <= in_slot_idx;
      req_slot_ok_r <= in_slot_ok;
    end
  end

  // Sequencer
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: if (in_accept) state_nxt = ST_EXEC;
      ST_EXEC: state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  logic exec;
  assign exec = (state_r == ST_EXEC);

  // Memories: bitmap word and cursor pair per space
  logic              map_wr_en;
  logic [SLOTS-1:0]  map_wr_data;
  logic [SLOTS-1:0]  map_rd_data;
  logic              cur_wr_en;
  logic [2*CW-1:0]   cur_wr_data;
  logic [2*CW-1:0]   cur_rd_data;

  bsa_ram #(.WIDTH(SLOTS), .DEPTH(SPACES)) u_map_ram (
    .clk     (clk),
    .wr_en   (map_wr_en),
    .wr_addr (req_sp_r),
    .wr_data (map_wr_data),
    .rd_en   (in_accept),
    .rd_addr (in_sp_idx),
    .rd_data (map_rd_data)
  );

  bsa_ram #(.WIDTH(2 * CW), .DEPTH(SPACES)) u_cur_ram (
    .clk     (clk),
    .wr_en   (cur_wr_en),
    .wr_addr (req_sp_r),
    .wr_data (cur_wr_data),
    .rd_en   (in_accept),
    .rd_addr (in_sp_idx),
    .rd_data (cur_rd_data)
  );

  // Per-space valid and cursor-started flags
  logic [SPACES-1:0] map_vld_r;
  logic [SPACES-1:0] auto_set_r;
  logic [SPACES-1:0] bl_set_r;

  // Execute: search, update and write back
  logic             is_take;
  logic             is_auto;
  logic             take_ok;
  logic             cur_set;
  logic [CW-1:0]    cur_raw;
  logic [CW-1:0]    cursor;
  logic [SLOTS-1:0] map_word;
  logic             find_found;
  logic [LW-1:0]    find_idx;
  logic [CW-1:0]    cur_new;
  logic [SLOTS-1:0] mark_vec;
  logic [31:0]      grant_ext;

  assign is_take  = (req_func_r == FUNC_TAKE_AUTO) || (req_func_r == FUNC_TAKE_BINDLESS);
  assign is_auto  = (req_func_r == FUNC_TAKE_AUTO);
  assign take_ok  = is_take && req_sp_ok_r;
  assign cur_set  = is_auto ? auto_set_r[req_sp_r] : bl_set_r[req_sp_r];
  assign cur_raw  = is_auto ? cur_rd_data[CW-1:0] : cur_rd_data[2*CW-1:CW];
  assign cursor   = cur_set ? cur_raw : CW'(is_auto ? auto_start_r : bl_start_r);
  assign map_word = map_vld_r[req_sp_r] ? map_rd_data : '0;

  bsa_find #(.SLOTS(SLOTS), .LW(LW), .CW(CW)) u_find (
    .used   (map_word),
    .cursor (cursor),
    .found  (find_found),
    .idx    (find_idx)
  );

  always_comb begin
    mark_vec = '0;
    if (is_take) begin
      mark_vec[find_idx] = 1'b1;
    end else begin
      mark_vec[req_slot_r] = 1'b1;
    end
  end

  assign cur_new     = find_found ? (CW'(find_idx) + CW'(1)) : cursor;
  assign map_wr_en   = exec && ((req_func_r == FUNC_RESERVE && req_sp_ok_r && req_slot_ok_r)
                                || (take_ok && find_found));
  assign map_wr_data = map_word | mark_vec;
  assign cur_wr_en   = exec && take_ok;
  assign cur_wr_data = is_auto ? {cur_rd_data[2*CW-1:CW], cur_new}
                               : {cur_new, cur_rd_data[CW-1:0]};
  assign grant_ext   = 32'(find_idx);

  // Flag bookkeeping; a restart drops every cursor at once
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      map_vld_r  <= '0;
      auto_set_r <= '0;
      bl_set_r   <= '0;
    end else if (exec) begin
      if (map_wr_en) begin
        map_vld_r[req_sp_r] <= 1'b1;
      end
      if (req_func_r == FUNC_RESTART) begin
        auto_set_r <= '0;
        bl_set_r   <= '0;
      end else if (take_ok) begin
        if (is_auto) begin
          auto_set_r[req_sp_r] <= 1'b1;
        end else begin
          bl_set_r[req_sp_r] <= 1'b1;
        end
      end
    end
  end

  // Result register
  logic [GRANT_W-1:0] grant_r;
  logic               full_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (exec) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (exec) begin
      grant_r <= (take_ok && find_found) ? grant_ext[GRANT_W-1:0] : '0;
      full_r  <= is_take && (!req_sp_ok_r || !find_found);
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{(OUT_DATA_W - GRANT_W){1'b0}}, grant_r};
  assign out_tuser  = full_r;

endmodule

`default_nettype wire

### rtl/core/bsa_ram.sv
// ----------------------------------------------------------------------------
// bsa_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module bsa_ram #(
  parameter int unsigned WIDTH = 64,
  parameter int unsigned DEPTH = 8
) (
  input  wire logic                                   clk,
  input  wire logic                                   wr_en,
  input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]                       wr_data,
  input  wire logic                                   rd_en,
  input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
  output logic      [WIDTH-1:0]                       rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  // Write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem_r[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

`default_nettype wire

### rtl/core/bsa_find.sv
// ----------------------------------------------------------------------------
// bsa_find
// Masked priority encoder: lowest free slot at or above the cursor.
// ----------------------------------------------------------------------------
`default_nettype none

module bsa_find #(
  parameter int unsigned SLOTS = 64,
  parameter int unsigned LW    = 6,
  parameter int unsigned CW    = 7
) (
  input  wire logic [SLOTS-1:0] used,
  input  wire logic [CW-1:0]    cursor,
  output logic                  found,
  output logic      [LW-1:0]    idx
);

  logic [SLOTS-1:0] free_vec;

  // Keep only free slots at or above the cursor
  always_comb begin
    for (int i = 0; i < SLOTS; i++) begin
      free_vec[i] = !used[i] && ($unsigned(i) >= 32'(cursor));
    end
  end

  // Pick the lowest candidate
  always_comb begin
    idx = '0;
    for (int i = SLOTS - 1; i >= 0; i--) begin
      if (free_vec[i]) begin
        idx = LW'(i);
      end
    end
  end

  assign found = |free_vec;

endmodule

`default_nettype wire
